// ----- rtl/grb_pkg.sv -----
`default_nettype none

package grb_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned LINE_COLS   = (MAX_WIDTH + 1) / 2;
  localparam int unsigned NUM_BANKS   = 2;
  localparam int unsigned BANK_DEPTH  = (LINE_COLS + 1) / 2;
  localparam int unsigned BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned JW          = BANK_AW + 1;
  localparam int unsigned CW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW          = $clog2(MAX_WIDTH + 1);

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 11;
  localparam int unsigned LINE_W      = 3 * SUM_W;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned ROUND_SHIFT = 6;
  localparam int unsigned ROUND_ADD   = 1 << (ROUND_SHIFT - 1);

  localparam int unsigned CFG_W_BITS  = 13;
  localparam int unsigned CFG_H_BITS  = 16;
  localparam int unsigned CFG_DW      = 16;
  localparam int unsigned CFG_IW      = 1;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned RES_NW      = $clog2(MAX_RES + 1);
  localparam int unsigned SUB_W       = $clog2(MAX_RES);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QAW         = $clog2(QDEPTH);
  localparam int unsigned QCW         = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    RK_FULL,
    RK_LAST_EVEN,
    RK_LAST_ODD
  } row_kind_e;

  typedef struct packed {
    logic             vld;
    logic [JW-1:0]    j;
    logic [SUM_W-1:0] h;
    logic             eor;
  } col_ev_t;

  typedef struct packed {
    logic      vld;
    row_kind_e kind;
    logic      last;
  } row_ev_t;

  typedef struct packed {
    col_ev_t [1:0] ev;
    row_ev_t [1:0] rw;
    logic          first_row;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             eof;
  } res_t;

  typedef struct packed {
    logic [RES_NW-1:0]     n;
    res_t [MAX_RES-1:0]    res;
  } bundle_t;

endpackage

`default_nettype wire

// ----- rtl/grb_if.sv -----
`default_nettype none

interface grb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface grb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic       last_in_run;
  logic       end_of_row;
  logic       end_of_frame;

  modport source (output valid, output out_pixel, output last_in_run, output end_of_row,
                  output end_of_frame, input ready);
  modport sink (input valid, input out_pixel, input last_in_run, input end_of_row,
                input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/grb_ram.sv -----
`default_nettype none

module grb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/grb_front.sv -----
`default_nettype none

module grb_front import grb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic              accept_i,
  output job_t              job_o
);

  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;
  logic [CW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [PIX_W-1:0]      win_q [3];
  logic [PIX_W-1:0]      ew [3];

  logic [WW-1:0]         w_eff;
  logic [ROW_W-1:0]      h_eff;
  logic                  col_wrap;
  logic [CW-1:0]         c;
  logic [ROW_W:0]        r_inc;
  logic [ROW_W-1:0]      r;
  logic                  last_col, last_row;
  logic [JW-1:0]         ow_last;
  logic [ROW_W-1:0]      oh_last;
  col_ev_t               ev_a, ev_b;
  row_ev_t               rw_a, rw_b;
  logic [ROW_W-1:0]      krow_a, krow_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == '0) ? ROW_W'(1) : height_q;

    col_wrap = 32'(col_q) >= 32'(w_eff);
    c        = col_wrap ? '0 : col_q;
    r_inc    = col_wrap ? ((ROW_W+1)'(row_q) + 1'b1) : (ROW_W+1)'(row_q);
    r        = (r_inc >= (ROW_W+1)'(h_eff)) ? '0 : r_inc[ROW_W-1:0];
    last_col = 32'(c) == (32'(w_eff) - 32'd1);
    last_row = r == (h_eff - 1'b1);
    ow_last  = JW'((w_eff - 1'b1) >> 1);
    oh_last  = (h_eff - 1'b1) >> 1;

    for (int k = 0; k < 3; k++) begin
      ew[k] = (c == '0) ? pixel_i : win_q[k];
    end

    ev_a.vld = !c[0] && (c != '0);
    ev_a.j   = JW'(c >> 1) - 1'b1;
    ev_a.h   = SUM_W'(ew[2]) + SUM_W'(ew[1]) * SUM_W'(3) + SUM_W'(ew[0]) * SUM_W'(3)
             + SUM_W'(pixel_i);
    ev_a.eor = ev_a.j == ow_last;

    ev_b.vld = last_col;
    ev_b.j   = JW'(c >> 1);
    if (c[0]) begin
      ev_b.h = SUM_W'(ew[1]) + SUM_W'(ew[0]) * SUM_W'(3) + SUM_W'(pixel_i) * SUM_W'(4);
    end else begin
      ev_b.h = SUM_W'(ew[0]) + SUM_W'(pixel_i) * SUM_W'(7);
    end
    ev_b.eor = ev_b.j == ow_last;

    krow_a   = (r >> 1) - 1'b1;
    rw_a.vld  = !r[0] && (r != '0);
    rw_a.kind = RK_FULL;
    rw_a.last = krow_a == oh_last;

    krow_b   = r >> 1;
    rw_b.vld  = last_row;
    rw_b.kind = r[0] ? RK_LAST_ODD : RK_LAST_EVEN;
    rw_b.last = krow_b == oh_last;

    job_o.ev[0]     = ev_a.vld ? ev_a : ev_b;
    job_o.ev[1]     = ev_b;
    job_o.ev[1].vld = ev_a.vld && ev_b.vld;
    job_o.rw[0]     = rw_a.vld ? rw_a : rw_b;
    job_o.rw[1]     = rw_b;
    job_o.rw[1].vld = rw_a.vld && rw_b.vld;
    job_o.first_row = r == '0;

    col_d = last_col ? '0 : (c + 1'b1);
    if (!last_col) begin
      row_d = r;
    end else if (last_row) begin
      row_d = '0;
    end else begin
      row_d = r + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int k = 0; k < 3; k++) begin
        win_q[k] <= '0;
      end
    end else if (accept_i) begin
      col_q    <= col_d;
      row_q    <= row_d;
      win_q[2] <= ew[1];
      win_q[1] <= ew[0];
      win_q[0] <= pixel_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/grb_line.sv -----
`default_nettype none

module grb_line import grb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  job_t    job_i,
  output logic    s1_valid_o,
  output logic    push_o,
  output bundle_t bundle_o
);

  job_t                job_q;
  logic                s1_vld_q;

  logic [BANK_AW-1:0]  raddr [NUM_BANKS];
  logic [LINE_W-1:0]   rdata [NUM_BANKS];
  logic                we    [NUM_BANKS];
  logic [BANK_AW-1:0]  waddr [NUM_BANKS];
  logic [LINE_W-1:0]   wdata [NUM_BANKS];
  logic                last_we_q   [NUM_BANKS];
  logic [BANK_AW-1:0]  last_addr_q [NUM_BANKS];
  logic [LINE_W-1:0]   last_data_q [NUM_BANKS];

  logic                slot_bank [2];
  logic [BANK_AW-1:0]  slot_addr [2];
  logic                fwd       [2];
  logic [LINE_W-1:0]   old_line  [2];
  logic [LINE_W-1:0]   new_line  [2];
  logic [PIX_W-1:0]    vpix      [2][2];

  function automatic logic [PIX_W-1:0] vfilt(row_kind_e kind, logic [SUM_W-1:0] l0,
                                             logic [SUM_W-1:0] l1, logic [SUM_W-1:0] l2,
                                             logic [SUM_W-1:0] h);
    logic [SUM_W+3:0] s;
    logic [SUM_W+3:0] t;
    case (kind)
      RK_FULL:      s = (SUM_W+4)'(l2) + (SUM_W+4)'(l1) * (SUM_W+4)'(3)
                      + (SUM_W+4)'(l0) * (SUM_W+4)'(3) + (SUM_W+4)'(h);
      RK_LAST_EVEN: s = (SUM_W+4)'(l0) + (SUM_W+4)'(h) * (SUM_W+4)'(7);
      RK_LAST_ODD:  s = (SUM_W+4)'(l1) + (SUM_W+4)'(l0) * (SUM_W+4)'(3)
                      + (SUM_W+4)'(h) * (SUM_W+4)'(4);
      default:      s = '0;
    endcase
    t = (s + (SUM_W+4)'(ROUND_ADD)) >> ROUND_SHIFT;
    return (t > (SUM_W+4)'(255)) ? PIX_W'(255) : t[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_q <= job_i;
    end
  end

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    logic sel0, sel1;

    assign raddr[k] = (job_i.ev[0].j[0] == 1'(k)) ? job_i.ev[0].j[JW-1:1]
                                                   : job_i.ev[1].j[JW-1:1];
    assign sel0     = job_q.ev[0].vld && (job_q.ev[0].j[0] == 1'(k));
    assign sel1     = job_q.ev[1].vld && (job_q.ev[1].j[0] == 1'(k));
    assign we[k]    = s1_vld_q && (sel0 || sel1);
    assign waddr[k] = sel0 ? slot_addr[0] : slot_addr[1];
    assign wdata[k] = sel0 ? new_line[0] : new_line[1];

    grb_ram #(
      .WIDTH (LINE_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (waddr[k]),
      .wdata_i (wdata[k]),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        last_we_q[k] <= 1'b0;
      end else begin
        last_we_q[k] <= we[k];
      end
    end

    always_ff @(posedge clk_i) begin
      last_addr_q[k] <= waddr[k];
      last_data_q[k] <= wdata[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      slot_bank[i] = job_q.ev[i].j[0];
      slot_addr[i] = job_q.ev[i].j[JW-1:1];
      fwd[i]       = last_we_q[slot_bank[i]] && (last_addr_q[slot_bank[i]] == slot_addr[i]);
      if (job_q.first_row) begin
        old_line[i] = {3{job_q.ev[i].h}};
      end else if (fwd[i]) begin
        old_line[i] = last_data_q[slot_bank[i]];
      end else begin
        old_line[i] = rdata[slot_bank[i]];
      end
      new_line[i] = {old_line[i][2*SUM_W-1:SUM_W], old_line[i][SUM_W-1:0], job_q.ev[i].h};
      for (int m = 0; m < 2; m++) begin
        vpix[m][i] = vfilt(job_q.rw[m].kind, old_line[i][SUM_W-1:0],
                           old_line[i][2*SUM_W-1:SUM_W], old_line[i][3*SUM_W-1:2*SUM_W],
                           job_q.ev[i].h);
      end
    end
  end

  always_comb begin
    bundle_o = '0;
    if (!job_q.ev[0].vld || !job_q.rw[0].vld) begin
      bundle_o.n = '0;
    end else if (job_q.ev[1].vld && job_q.rw[1].vld) begin
      bundle_o.n = RES_NW'(4);
    end else if (job_q.ev[1].vld || job_q.rw[1].vld) begin
      bundle_o.n = RES_NW'(2);
    end else begin
      bundle_o.n = RES_NW'(1);
    end

    bundle_o.res[0].pix = vpix[0][0];
    bundle_o.res[0].eor = job_q.ev[0].eor;
    bundle_o.res[0].eof = job_q.ev[0].eor && job_q.rw[0].last;
    if (job_q.ev[1].vld) begin
      bundle_o.res[1].pix = vpix[0][1];
      bundle_o.res[1].eor = job_q.ev[1].eor;
      bundle_o.res[1].eof = job_q.ev[1].eor && job_q.rw[0].last;
      bundle_o.res[2].pix = vpix[1][0];
      bundle_o.res[2].eor = job_q.ev[0].eor;
      bundle_o.res[2].eof = job_q.ev[0].eor && job_q.rw[1].last;
      bundle_o.res[3].pix = vpix[1][1];
      bundle_o.res[3].eor = job_q.ev[1].eor;
      bundle_o.res[3].eof = job_q.ev[1].eor && job_q.rw[1].last;
    end else begin
      bundle_o.res[1].pix = vpix[1][0];
      bundle_o.res[1].eor = job_q.ev[0].eor;
      bundle_o.res[1].eof = job_q.ev[0].eor && job_q.rw[1].last;
    end
  end

  assign push_o     = s1_vld_q && (bundle_o.n != '0);
  assign s1_valid_o = s1_vld_q;

endmodule

`default_nettype wire

// ----- rtl/grb_outq.sv -----
`default_nettype none

module grb_outq import grb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bundle_t        bundle_i,
  output logic [QCW-1:0] count_o,
  grb_res_if.source      res_o
);

  bundle_t          bq_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QCW-1:0]   cnt_q;
  logic [SUB_W-1:0] sub_q;
  bundle_t          head;
  res_t             cur;
  logic             last, pop, done;

  assign head = bq_q[rptr_q];
  assign cur  = head.res[sub_q];
  assign last = RES_NW'(sub_q) == (head.n - 1'b1);
  assign pop  = res_o.valid && res_o.ready;
  assign done = pop && last;

  assign res_o.valid        = cnt_q != '0;
  assign res_o.out_pixel    = cur.pix;
  assign res_o.last_in_run  = last;
  assign res_o.end_of_row   = cur.eor;
  assign res_o.end_of_frame = cur.eof;
  assign count_o            = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bq_q[wptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      sub_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (done) begin
        rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (pop) begin
        sub_q <= last ? '0 : sub_q + 1'b1;
      end
      cnt_q <= cnt_q + QCW'(push_i) - QCW'(done);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gray_binomial_reduce_4x4.sv -----
// Gray image 2:1 reducer with a separable 1-3-3-1 binomial filter.
// pix_i takes 8-bit source pixels in raster order, one per transfer; res_o
// gives the reduced image, ceil(W/2) x ceil(H/2), in raster order, with flags
// for the last result of each source pixel, the end of an output row and the
// end of the output image. A source pixel yields zero to four results.
// Image size is set through cfg_we_i/cfg_idx_i/cfg_data_i (index 0 width,
// index 1 height) between frames, while no results are pending.
// Throughput: one source pixel per cycle while pix_i.ready is high. Horizontal
// sums of the last three source rows live in two line-store RAM banks (even
// and odd output column), each read and written once per cycle, so the two
// columns finished by the last pixel of a row go in the same cycle.
// Path: each pixel transfer passes the RAM read register, then the result
// queue. A pixel that finishes several results, such as the last of an image,
// leaves them in one queue entry that drains at one result per cycle while
// res_o.ready is high; pix_i.ready stays high unless the queue fills.
// Stall: the queue holds four per-pixel entries of up to four results each;
// pix_i.ready drops when the queue and the pixel in the RAM stage could fill it.
// Reset: counters and pixel window clear, the size returns to 640 x 480;
// the line stores are rebuilt from the first row of each frame.
`default_nettype none

module gray_binomial_reduce_4x4 import grb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  grb_pix_if.sink           pix_i,
  grb_res_if.source         res_o
);

  job_t           job;
  bundle_t        bundle;
  logic           accept, in_ready, s1_valid, push;
  logic [QCW-1:0] q_count;

  assign in_ready    = (32'(q_count) + 32'(s1_valid)) < QDEPTH;
  assign pix_i.ready = in_ready;
  assign accept      = pix_i.valid && in_ready;

  grb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (pix_i.pixel),
    .accept_i   (accept),
    .job_o      (job)
  );

  grb_line u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .job_i      (job),
    .s1_valid_o (s1_valid),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  grb_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .count_o  (q_count),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire
